/* rtl/rv32ex_pkg.sv */
package rv32ex_pkg;

  localparam int DEF_CODE_ADDR_BITS = 16;
  localparam int XLEN = 32;
  localparam int NUM_REGS = 32;
  localparam int REG_IDX_BITS = $clog2(NUM_REGS);

  localparam logic [XLEN-1:0] JALR_MASK = 32'hFFFF_FFFE;

  // opcode field, instruction bits 6:2
  localparam logic [4:0] OPC_LOAD   = 5'd0;
  localparam logic [4:0] OPC_OP_IMM = 5'd4;
  localparam logic [4:0] OPC_AUIPC  = 5'd5;
  localparam logic [4:0] OPC_STORE  = 5'd8;
  localparam logic [4:0] OPC_OP     = 5'd12;
  localparam logic [4:0] OPC_LUI    = 5'd13;
  localparam logic [4:0] OPC_BRANCH = 5'd24;
  localparam logic [4:0] OPC_JALR   = 5'd25;
  localparam logic [4:0] OPC_JAL    = 5'd27;
  localparam logic [4:0] OPC_SYSTEM = 5'd28;

  // instruction formats
  localparam logic [2:0] FMT_R = 3'd0;
  localparam logic [2:0] FMT_I = 3'd1;
  localparam logic [2:0] FMT_S = 3'd2;
  localparam logic [2:0] FMT_B = 3'd3;
  localparam logic [2:0] FMT_U = 3'd4;
  localparam logic [2:0] FMT_J = 3'd5;

  // ALU func3
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  // branch func3
  localparam logic [2:0] BR_EQ  = 3'd0;
  localparam logic [2:0] BR_NE  = 3'd1;
  localparam logic [2:0] BR_LT  = 3'd4;
  localparam logic [2:0] BR_GE  = 3'd5;
  localparam logic [2:0] BR_LTU = 3'd6;
  localparam logic [2:0] BR_GEU = 3'd7;

  typedef struct packed {
    logic [15:0]             pc;
    logic [4:0]              opcode;
    logic [2:0]              instr_type;
    logic [2:0]              func;
    logic                    alt_bit;
    logic [REG_IDX_BITS-1:0] rs1_index;
    logic [REG_IDX_BITS-1:0] rs2_index;
    logic [REG_IDX_BITS-1:0] rd_index;
    logic signed [19:0]      imm;
  } in_item_t;

  typedef struct packed {
    logic [15:0]             next_pc;
    logic signed [XLEN-1:0]  result_value;
    logic                    reg_written;
  } out_item_t;

  typedef struct packed {
    logic                    en;
    logic [REG_IDX_BITS-1:0] addr;
    logic [XLEN-1:0]         data;
  } wr_req_t;

endpackage

/* rtl/rv32i_execute_stage.sv */
// An accepted request passes two registers, the operand stage and then the result register, before it shows on out_*.
// Throughput: one request per cycle while out_ready stays high; the register file is read at the
//   accept edge and written when the request moves into the result register.
// A write at the same edge as a read is forwarded inside the register file.
// Reset (rst_n low, synchronous) empties both stages and clears the register
//   file valid flags; no clearing pass.
module rv32i_execute_stage #(
  parameter int CODE_ADDR_BITS = rv32ex_pkg::DEF_CODE_ADDR_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  rv32ex_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output rv32ex_pkg::out_item_t out_data
);
  import rv32ex_pkg::*;

  // operand stage: decoded request plus registered operands
  logic      s1_valid_r;
  logic      s1_valid_nxt;
  in_item_t  s1_item_r;
  // result stage
  logic      out_valid_r;
  logic      out_valid_nxt;
  out_item_t out_data_r;

  logic            accept;
  logic            s1_adv;
  logic [XLEN-1:0] rs1_val;
  logic [XLEN-1:0] rs2_val;
  out_item_t       core_res;
  wr_req_t         core_wr;
  wr_req_t         rf_wr;

  // advance the operand stage when the result register is free or being drained
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  // take a new request whenever the operand stage empties this cycle
  assign in_ready = !s1_valid_r || s1_adv;
  assign accept   = in_valid && in_ready;

  // commit the register write only as the request leaves the operand stage
  assign rf_wr.en   = core_wr.en && s1_adv;
  assign rf_wr.addr = core_wr.addr;
  assign rf_wr.data = core_wr.data;

  rv32ex_regfile u_regfile (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (accept),
    .raddr1 (in_data.rs1_index),
    .raddr2 (in_data.rs2_index),
    .wr     (rf_wr),
    .rdata1 (rs1_val),
    .rdata2 (rs2_val)
  );

  rv32ex_core #(
    .CODE_ADDR_BITS (CODE_ADDR_BITS)
  ) u_core (
    .item    (s1_item_r),
    .rs1_val (rs1_val),
    .rs2_val (rs2_val),
    .res     (core_res),
    .wr      (core_wr)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload: hold while stalled, load on advance
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= in_data;
    end
    if (s1_adv) begin
      out_data_r <= core_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  // register zero is never written
  a_no_x0_write: assert property (@(posedge clk) disable iff (!rst_n)
    rf_wr.en |-> (rf_wr.addr != '0))
    else $error("write to register zero");

  // an empty operand stage always takes a request
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ready)
    else $error("in_ready low with empty operand stage");

  // an accepted request lands in the operand stage
  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_valid_r)
    else $error("accepted request lost");

  // an advancing request is offered on the output next cycle with matching flag
  a_adv_offers: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> (out_valid_r && out_data_r.reg_written == $past(core_wr.en)))
    else $error("advanced request not offered");
`endif

endmodule

/* rtl/rv32ex_regfile.sv */
module rv32ex_regfile (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                rd_en,
  input  logic [rv32ex_pkg::REG_IDX_BITS-1:0] raddr1,
  input  logic [rv32ex_pkg::REG_IDX_BITS-1:0] raddr2,
  input  rv32ex_pkg::wr_req_t                 wr,
  output logic [rv32ex_pkg::XLEN-1:0]         rdata1,
  output logic [rv32ex_pkg::XLEN-1:0]         rdata2
);
  import rv32ex_pkg::*;

  logic [XLEN-1:0]     mem [NUM_REGS];
  logic [NUM_REGS-1:0] valid_r;
  logic [XLEN-1:0]     rdata1_r;
  logic [XLEN-1:0]     rdata2_r;
  logic                v1_r;
  logic                v2_r;
  logic                hit1;
  logic                hit2;

  // a write at the same edge as the read passes straight through
  assign hit1 = wr.en && (wr.addr == raddr1);
  assign hit2 = wr.en && (wr.addr == raddr2);

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rdata1_r <= hit1 ? wr.data : mem[raddr1];
      rdata2_r <= hit2 ? wr.data : mem[raddr2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
    end else begin
      if (wr.en) begin
        valid_r[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        v1_r <= hit1 || valid_r[raddr1];
        v2_r <= hit2 || valid_r[raddr2];
      end
    end
  end

  // unwritten entries read as zero
  assign rdata1 = v1_r ? rdata1_r : '0;
  assign rdata2 = v2_r ? rdata2_r : '0;

endmodule

/* rtl/rv32ex_core.sv */
module rv32ex_core #(
  parameter int CODE_ADDR_BITS = rv32ex_pkg::DEF_CODE_ADDR_BITS
) (
  input  rv32ex_pkg::in_item_t        item,
  input  logic [rv32ex_pkg::XLEN-1:0] rs1_val,
  input  logic [rv32ex_pkg::XLEN-1:0] rs2_val,
  output rv32ex_pkg::out_item_t       res,
  output rv32ex_pkg::wr_req_t         wr
);
  import rv32ex_pkg::*;

  localparam logic [XLEN-1:0] ADDR_MASK = XLEN'((64'd1 << CODE_ADDR_BITS) - 64'd1);

  logic [XLEN-1:0] pc32;
  logic [XLEN-1:0] imm32;
  logic [XLEN-1:0] pc4;
  logic [XLEN-1:0] link;
  logic [XLEN-1:0] step_off;
  logic [XLEN-1:0] upper;
  logic [XLEN-1:0] jalr_sum;
  logic [XLEN-1:0] opb;
  logic [4:0]      shamt;
  logic            is_r;
  logic [XLEN-1:0] alu_out;
  logic            taken;
  logic [XLEN-1:0] result;
  logic [XLEN-1:0] npc;
  logic            wen;

  assign pc32     = {16'd0, item.pc} & ADDR_MASK;
  assign imm32    = XLEN'(item.imm);
  assign pc4      = {pc32[XLEN-3:0], 2'b00};
  assign link     = pc4 + XLEN'(4);
  assign step_off = XLEN'($signed(imm32) >>> 1);
  assign upper    = {item.imm, 12'd0};
  assign jalr_sum = rs1_val + imm32;

  assign is_r  = (item.instr_type == FMT_R);
  assign opb   = is_r ? rs2_val : imm32;
  assign shamt = is_r ? rs2_val[4:0] : item.rs2_index;

  always_comb begin
    case (item.func)
      F3_ADD:  alu_out = (is_r && item.alt_bit) ? rs1_val - opb : rs1_val + opb;
      F3_SLL:  alu_out = rs1_val << shamt;
      F3_SLT:  alu_out = XLEN'($signed(rs1_val) < $signed(opb));
      F3_SLTU: alu_out = XLEN'(rs1_val < opb);
      F3_XOR:  alu_out = rs1_val ^ opb;
      F3_SR:   alu_out = item.alt_bit ? XLEN'($signed(rs1_val) >>> shamt)
                                      : rs1_val >> shamt;
      F3_OR:   alu_out = rs1_val | opb;
      default: alu_out = rs1_val & opb;
    endcase
  end

  always_comb begin
    case (item.func)
      BR_EQ:   taken = (rs1_val == rs2_val);
      BR_NE:   taken = (rs1_val != rs2_val);
      BR_LT:   taken = ($signed(rs1_val) < $signed(rs2_val));
      BR_GE:   taken = !($signed(rs1_val) < $signed(rs2_val));
      BR_LTU:  taken = (rs1_val < rs2_val);
      BR_GEU:  taken = (rs1_val >= rs2_val);
      default: taken = 1'b0;
    endcase
  end

  always_comb begin
    result = '0;
    npc    = pc32 + XLEN'(1);
    case (item.instr_type)
      FMT_R: result = alu_out;
      FMT_I: begin
        if (item.opcode == OPC_JALR) begin
          result = link;
          npc    = (jalr_sum & JALR_MASK) >> 2;
        end else if (item.opcode == OPC_OP_IMM) begin
          result = alu_out;
        end
      end
      FMT_B: begin
        result = XLEN'(taken);
        if (taken) begin
          npc = pc32 + step_off;
        end
      end
      FMT_U: result = (item.opcode == OPC_LUI) ? upper : pc4 + upper;
      FMT_J: begin
        result = link;
        npc    = pc32 + step_off;
      end
      default: result = '0;
    endcase
  end

  assign wen = (item.rd_index != '0) && !(item.opcode inside {OPC_BRANCH, OPC_STORE});

  assign res.next_pc      = 16'(npc & ADDR_MASK);
  assign res.result_value = result;
  assign res.reg_written  = wen;

  assign wr.en   = wen;
  assign wr.addr = item.rd_index;
  assign wr.data = result;

endmodule

/* tb/sv/rv32i_execute_stage_test.sv */
`timescale 1ns / 100ps

module rv32i_execute_stage_test;
  import rv32ex_pkg::*;

  // Code address width used by the instance below (its default).
  localparam int          CODE_BITS   = DEF_CODE_ADDR_BITS;
  localparam logic [31:0] CODE_MASK   = (32'd1 << CODE_BITS) - 32'd1;
  // Formats 6 and 7 decode to nothing; use one of them for the unknown-format case.
  localparam logic [2:0]  FMT_UNKNOWN = 3'd7;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  // Requests waiting to be driven, and results predicted for accepted requests.
  in_item_t  instr_queue[$];
  out_item_t pending_results[$];

  // Architectural copy of the register file; entry 0 is never written.
  logic [31:0] arch_regs [0:31];

  // Opcodes that make up well-formed random instructions; OP_IMM twice to weight the ALU.
  logic [4:0] legal_opcodes [0:10] = '{OPC_OP, OPC_OP_IMM, OPC_OP_IMM, OPC_LUI, OPC_AUIPC,
                                       OPC_BRANCH, OPC_JAL, OPC_JALR, OPC_LOAD, OPC_STORE,
                                       OPC_SYSTEM};

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit in_fire        = 1'b0;
  int n_sent         = 0;
  int n_directed     = 0;
  int n_checked      = 0;
  int n_writes       = 0;
  int n_errors       = 0;

  rv32i_execute_stage u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // 20 ns clock: low half, then high half.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // ALU for register and immediate forms. Immediate shifts take the amount from
  // the rs2 field; SUB exists only in the register form.
  function automatic logic [31:0] alu_result(logic [31:0] a, logic [31:0] b, logic [2:0] f3,
                                             logic alt, logic is_r, logic [4:0] rs2f);
    logic [4:0]  sh;
    logic [31:0] y;
    sh = is_r ? b[4:0] : rs2f;
    case (f3)
      F3_ADD:  y = (is_r && alt) ? a - b : a + b;
      F3_SLL:  y = a << sh;
      F3_SLT:  y = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
      F3_SLTU: y = (a < b) ? 32'd1 : 32'd0;
      F3_XOR:  y = a ^ b;
      F3_SR: begin
        // keep the arithmetic shift in a statement of its own so it stays signed
        if (alt) y = $signed(a) >>> sh;
        else     y = a >> sh;
      end
      F3_OR:   y = a | b;
      default: y = a & b;
    endcase
    return y;
  endfunction

  // Branch condition; the two unused func3 codes never branch.
  function automatic logic cond_holds(logic [31:0] a, logic [31:0] b, logic [2:0] f3);
    case (f3)
      BR_EQ:   return a == b;
      BR_NE:   return a != b;
      BR_LT:   return $signed(a) < $signed(b);
      BR_GE:   return !($signed(a) < $signed(b));
      BR_LTU:  return a < b;
      BR_GEU:  return a >= b;
      default: return 1'b0;
    endcase
  endfunction

  // Execute one request against arch_regs and return the result it must produce.
  function automatic out_item_t execute_instr(in_item_t op);
    logic [31:0]        a;
    logic [31:0]        b;
    logic [31:0]        immx;
    logic [31:0]        pc_w;
    logic [31:0]        pc4;
    logic [31:0]        link;
    logic [31:0]        res;
    logic [31:0]        npc;
    logic signed [31:0] half_off;
    logic               wr;
    out_item_t          r;
    a        = arch_regs[op.rs1_index];
    b        = arch_regs[op.rs2_index];
    immx     = {{12{op.imm[19]}}, op.imm};
    pc_w     = {16'd0, op.pc} & CODE_MASK;
    pc4      = pc_w << 2;
    link     = pc4 + 32'd4;
    res      = 32'd0;
    npc      = pc_w + 32'd1;
    half_off = $signed(immx) >>> 1;
    case (op.instr_type)
      FMT_R: res = alu_result(a, b, op.func, op.alt_bit, 1'b1, op.rs2_index);
      FMT_I: begin
        if (op.opcode == OPC_JALR) begin
          res = link;
          npc = ((a + immx) & JALR_MASK) >> 2;
        end else if (op.opcode == OPC_OP_IMM) begin
          res = alu_result(a, immx, op.func, op.alt_bit, 1'b0, op.rs2_index);
        end
      end
      FMT_B: begin
        if (cond_holds(a, b, op.func)) begin
          res = 32'd1;
          npc = pc_w + half_off;
        end
      end
      FMT_U: res = (op.opcode == OPC_LUI) ? (immx << 12) : (pc4 + (immx << 12));
      FMT_J: begin
        res = link;
        npc = pc_w + half_off;
      end
      default: ; // stores and unknown formats produce 0
    endcase
    // the write is gated by rd and opcode only, never by format
    wr = (op.rd_index != 5'd0) && (op.opcode != OPC_BRANCH) && (op.opcode != OPC_STORE);
    if (wr) arch_regs[op.rd_index] = res;
    r.next_pc      = 16'(npc & CODE_MASK);
    r.result_value = res;
    r.reg_written  = wr;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic queue_request(logic [15:0] pc, logic [4:0] opc, logic [2:0] fmt,
                               logic [2:0] f3, logic alt, logic [4:0] rs1, logic [4:0] rs2,
                               logic [4:0] rd, logic [19:0] imm);
    in_item_t op;
    op.pc         = pc;
    op.opcode     = opc;
    op.instr_type = fmt;
    op.func       = f3;
    op.alt_bit    = alt;
    op.rs1_index  = rs1;
    op.rs2_index  = rs2;
    op.rd_index   = rd;
    op.imm        = imm;
    instr_queue.push_back(op);
  endtask

  // Mostly well-formed instructions with random operands; the rest is raw noise
  // over every field, unknown formats and odd opcode/format pairs included.
  function automatic in_item_t rand_instr();
    in_item_t op;
    op.pc         = 16'($urandom);
    op.opcode     = 5'($urandom);
    op.instr_type = 3'($urandom);
    op.func       = 3'($urandom);
    op.alt_bit    = 1'($urandom);
    op.rs1_index  = 5'($urandom);
    op.rs2_index  = 5'($urandom);
    op.rd_index   = 5'($urandom);
    // bias the immediate toward small values and the two extremes
    case ($urandom_range(3))
      0:       op.imm = 20'($urandom_range(31)) - 20'd16;
      1:       op.imm = $urandom_range(1) ? 20'h80000 : 20'h7FFFF;
      default: op.imm = 20'($urandom);
    endcase
    if ($urandom_range(99) < 85) begin
      op.opcode = legal_opcodes[$urandom_range(10)];
      case (op.opcode)
        OPC_OP:              op.instr_type = FMT_R;
        OPC_LUI, OPC_AUIPC:  op.instr_type = FMT_U;
        OPC_BRANCH:          op.instr_type = FMT_B;
        OPC_JAL:             op.instr_type = FMT_J;
        OPC_STORE:           op.instr_type = FMT_S;
        default:             op.instr_type = FMT_I;
      endcase
      // equal sources make equality branches and SUB-to-zero reachable
      if ($urandom_range(99) < 20) op.rs2_index = op.rs1_index;
    end
    return op;
  endfunction

  // Hold until every queued request went out and every predicted result came back.
  task automatic wait_drained();
    while (instr_queue.size() != 0 || in_valid || pending_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic run_random(int count, int idle_pct, int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) instr_queue.push_back(rand_instr());
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Driver: present requests at the falling edge, one per handshake
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else if (!in_valid || in_fire) begin
      // the previous request is gone (or there was none): advance or idle
      if (instr_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data  <= instr_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    // otherwise hold valid and payload until the block takes the request
    out_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Monitor: check results and predict accepted requests at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t exp_r;
    in_fire = 1'b0;
    if (rst_n) begin
      // check first: a result leaving now belongs to an earlier request
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: next_pc %0d result_value %h reg_written %0b",
                 out_data.next_pc, out_data.result_value, out_data.reg_written);
          n_errors++;
        end else begin
          exp_r = pending_results.pop_front();
          n_checked++;
          if (exp_r.reg_written) n_writes++;
          if (out_data.next_pc !== exp_r.next_pc) begin
            $error("next_pc: expected %0d, got %0d", exp_r.next_pc, out_data.next_pc);
            n_errors++;
          end
          if (out_data.result_value !== exp_r.result_value) begin
            $error("result_value: expected %h, got %h",
                   exp_r.result_value, out_data.result_value);
            n_errors++;
          end
          if (out_data.reg_written !== exp_r.reg_written) begin
            $error("reg_written: expected %0b, got %0b",
                   exp_r.reg_written, out_data.reg_written);
            n_errors++;
          end
        end
      end
      // a request taken at this edge updates the predicted register file
      if (in_valid && in_ready) begin
        in_fire = 1'b1;
        pending_results.push_back(execute_instr(in_data));
        n_sent++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    // hold reset from time zero; the driver sets the channel inputs while it is low
    rst_n = 1'b0;
    for (int i = 0; i < 32; i++) arch_regs[i] = 32'd0;

    // Directed requests. Seed registers with the extremes first:
    // x1 = 0x80000000, x2 = -1, x3 = 0x7FFFF (ADD with alt set stays ADD in I form).
    queue_request(16'd0,    OPC_LUI,    FMT_U, F3_ADD, 1'b0, 5'd0, 5'd0, 5'd1, 20'h80000);
    queue_request(16'd1,    OPC_OP_IMM, FMT_I, F3_ADD, 1'b0, 5'd0, 5'd0, 5'd2, 20'hFFFFF);
    queue_request(16'd2,    OPC_OP_IMM, FMT_I, F3_ADD, 1'b1, 5'd0, 5'd0, 5'd3, 20'h7FFFF);
    // AUIPC at the last code word: untruncated link base, next pc wraps to 0
    queue_request(16'hFFFF, OPC_AUIPC,  FMT_U, F3_ADD, 1'b0, 5'd0, 5'd0, 5'd4, 20'h7FFFF);
    // U format with an opcode other than LUI behaves as AUIPC
    queue_request(16'd3,    OPC_OP,     FMT_U, F3_ADD, 1'b0, 5'd0, 5'd0, 5'd10, 20'hFFFFF);
    // every register-form ALU operation; shift amounts of 31 from x3 and x2
    queue_request(16'd4,    OPC_OP,     FMT_R, F3_ADD,  1'b0, 5'd1, 5'd2, 5'd5,  20'h0);
    queue_request(16'd5,    OPC_OP,     FMT_R, F3_ADD,  1'b1, 5'd1, 5'd3, 5'd6,  20'h0);
    queue_request(16'd6,    OPC_OP,     FMT_R, F3_SLL,  1'b0, 5'd2, 5'd3, 5'd7,  20'h0);
    queue_request(16'd7,    OPC_OP,     FMT_R, F3_SLT,  1'b0, 5'd1, 5'd3, 5'd8,  20'h0);
    queue_request(16'd8,    OPC_OP,     FMT_R, F3_SLTU, 1'b0, 5'd1, 5'd3, 5'd9,  20'h0);
    // register format under a LOAD opcode still runs the ALU
    queue_request(16'd9,    OPC_LOAD,   FMT_R, F3_XOR,  1'b0, 5'd2, 5'd3, 5'd11, 20'h0);
    queue_request(16'd10,   OPC_OP,     FMT_R, F3_SR,   1'b0, 5'd1, 5'd3, 5'd12, 20'h0);
    queue_request(16'd11,   OPC_OP,     FMT_R, F3_SR,   1'b1, 5'd1, 5'd2, 5'd13, 20'h0);
    queue_request(16'd12,   OPC_OP,     FMT_R, F3_OR,   1'b0, 5'd1, 5'd3, 5'd14, 20'h0);
    queue_request(16'd13,   OPC_OP,     FMT_R, F3_AND,  1'b0, 5'd2, 5'd3, 5'd15, 20'h0);
    // immediate arithmetic shift takes its amount from the rs2 field
    queue_request(16'd14,   OPC_OP_IMM, FMT_I, F3_SR,   1'b1, 5'd1, 5'd4, 5'd16, 20'h00404);
    // every branch condition; rd is nonzero but must not be written
    queue_request(16'd200,  OPC_BRANCH, FMT_B, BR_EQ,   1'b0, 5'd1, 5'd1, 5'd5,  20'h80000);
    queue_request(16'd201,  OPC_BRANCH, FMT_B, BR_NE,   1'b0, 5'd0, 5'd0, 5'd5,  20'h00010);
    queue_request(16'hFFFF, OPC_BRANCH, FMT_B, BR_LT,   1'b0, 5'd1, 5'd3, 5'd5,  20'h7FFFF);
    queue_request(16'd203,  OPC_BRANCH, FMT_B, BR_GE,   1'b0, 5'd1, 5'd3, 5'd5,  20'h00010);
    queue_request(16'd204,  OPC_BRANCH, FMT_B, BR_LTU,  1'b0, 5'd3, 5'd2, 5'd5,  20'h00006);
    queue_request(16'd205,  OPC_BRANCH, FMT_B, BR_GEU,  1'b0, 5'd2, 5'd3, 5'd5,  20'hFFFFE);
    // an unused branch condition never branches, even on equal operands
    queue_request(16'd206,  OPC_BRANCH, FMT_B, F3_SLTU, 1'b0, 5'd1, 5'd1, 5'd5,  20'h00010);
    // JAL to rd 0 with an odd negative offset: link computed, nothing written
    queue_request(16'd300,  OPC_JAL,    FMT_J, F3_ADD,  1'b0, 5'd0, 5'd0, 5'd0,  20'h80001);
    // JALR with an odd target: low bit cleared before the word shift
    queue_request(16'd301,  OPC_JALR,   FMT_I, F3_ADD,  1'b0, 5'd4, 5'd0, 5'd17, 20'h00003);
    // store yields 0 and is never written; load yields 0 and is written
    queue_request(16'd302,  OPC_STORE,  FMT_S, F3_ADD,  1'b0, 5'd1, 5'd2, 5'd18, 20'h00004);
    queue_request(16'd303,  OPC_LOAD,   FMT_I, F3_ADD,  1'b0, 5'd1, 5'd0, 5'd19, 20'h00004);
    // unknown format: result 0, fall through to pc + 1
    queue_request(16'd304,  OPC_SYSTEM, FMT_UNKNOWN, F3_AND, 1'b1, 5'd1, 5'd2, 5'd20,
                  20'h7FFFF);
    n_directed = instr_queue.size();

    // release reset on a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // each drain below also makes the sender pause until all results are back
    wait_drained();
    run_random(400, 0, 0);
    run_random(400, 62, 0);
    run_random(400, 0, 62);
    run_random(400, 30, 30);

    // let the two-stage pipeline settle; anything arriving now is unexpected
    repeat (8) @(posedge clk);

    $display("Executed %0d requests (%0d directed, rest random over four idle/stall mixes).",
             n_sent, n_directed);
    $display("Checked %0d results, %0d with a register write; %0d mismatches.",
             n_checked, n_writes, n_errors);
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("rv32i_execute_stage_test: PASS");
    end else begin
      $display("rv32i_execute_stage_test: FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #4000000;
    $display("Timeout: %0d results still outstanding.", pending_results.size());
    $display("rv32i_execute_stage_test: FAIL");
    $finish;
  end

endmodule
